@@ sv/sequential_list_engine_unit_defines.svh @@
// assertion macros for the sequential list engine
// no dependencies; included by the top level only
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLE_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("sle assertion failed");

// next-cycle implication
`define SLE_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("sle assertion failed");

`else

`define SLE_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define SLE_ASSERT_NXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

@@ sv/sle_pkg.sv @@
// shared types and constants of the sequential list engine
// no dependencies
package sle_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 11;
  localparam int VAL_W          = 32;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_READ   = 3'd3,
    MODE_LOCATE = 3'd4,
    MODE_PRED   = 3'd5,
    MODE_SUCC   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STREAM,
    ST_PUT,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]              mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] result_value;
    logic [POS_W-1:0]        result_position;
    logic [POS_W-1:0]        list_length;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic stream;
    logic put;
    logic deliver;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_stream;
    logic is_insert;
    logic stream_done;
    logic out_free;
  } sts_t;

endpackage

@@ sv/sle_ctrl.sv @@
// controller state machine of the sequential list engine
// depends on sle_pkg
module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sle_pkg::sts_t sts,
  output sle_pkg::cmd_t cmd
);

  sle_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sle_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sle_pkg::ST_CHECK;
      end
      sle_pkg::ST_CHECK: begin
        state_nxt = sts.go_stream ? sle_pkg::ST_STREAM : sle_pkg::ST_DONE;
      end
      sle_pkg::ST_STREAM: begin
        if (sts.stream_done) begin
          state_nxt = sts.is_insert ? sle_pkg::ST_PUT : sle_pkg::ST_DONE;
        end
      end
      sle_pkg::ST_PUT: begin
        state_nxt = sle_pkg::ST_DONE;
      end
      sle_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = sle_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      sle_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      sle_pkg::ST_CHECK: begin
        cmd.start = 1'b1;
      end
      sle_pkg::ST_STREAM: begin
        cmd.stream = 1'b1;
      end
      sle_pkg::ST_PUT: begin
        cmd.put = 1'b1;
      end
      sle_pkg::ST_DONE: begin
        cmd.deliver = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ sv/sle_dp.sv @@
// datapath of the sequential list engine: list store, scan cursor, result register
// depends on sle_pkg
module sle_dp #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sle_pkg::in_word_t  in_word,
  input  sle_pkg::cmd_t      cmd,
  output sle_pkg::sts_t      sts,
  output logic               out_valid,
  output sle_pkg::out_word_t out_word,
  input  logic               out_stall
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [2:0]                mode_r;
  logic [sle_pkg::POS_W-1:0] pos_r;
  logic [DATA_WIDTH-1:0]     val_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             rd_addr_r, rd_addr_q_r;
  logic [CW-1:0]             left_r;
  logic                      rd_vld_r;
  logic [DATA_WIDTH-1:0]     rdata_r, prev_r;
  logic                      found_r, pend_r;
  sle_pkg::status_t          status_r;
  logic [sle_pkg::VAL_W-1:0] rval_r;
  logic [sle_pkg::POS_W-1:0] rpos_r;
  logic                      out_valid_r;
  sle_pkg::out_word_t        out_word_r;

  logic [XW-1:0]         pos_x, n_x, p0_x;
  sle_pkg::status_t      chk_status;
  logic                  needs_stream, is_search;
  logic [AW-1:0]         start_addr;
  logic [CW-1:0]         start_left;
  logic                  issue, match;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  cap_val, cap_pos, use_prev, set_found, set_pend;
  logic [DATA_WIDTH-1:0] cap_src;
  logic signed [63:0]    val_ext, cap_ext;

  assign val_ext = 64'(signed'(in_word.value));
  assign cap_src = use_prev ? prev_r : rdata_r;
  assign cap_ext = 64'(signed'(cap_src));

  // request checks and scan setup
  always_comb begin
    pos_x        = XW'(pos_r);
    n_x          = XW'(count_r);
    p0_x         = pos_x - XW'(1);
    chk_status   = sle_pkg::STAT_OK;
    needs_stream = 1'b0;
    is_search    = 1'b0;
    start_addr   = '0;
    start_left   = '0;
    case (mode_r)
      sle_pkg::MODE_INSERT: begin
        if (pos_r == '0 || pos_x > n_x + XW'(1)) begin
          chk_status = sle_pkg::STAT_BAD_POS;
        end else if (count_r == CW'(CAPACITY)) begin
          chk_status = sle_pkg::STAT_FULL;
        end else begin
          needs_stream = 1'b1;
        end
        start_addr = AW'(n_x - XW'(1));
        start_left = CW'(n_x - p0_x);
      end
      sle_pkg::MODE_DELETE: begin
        if (pos_r == '0 || pos_x > n_x) begin
          chk_status = sle_pkg::STAT_BAD_POS;
        end else begin
          needs_stream = 1'b1;
        end
        start_addr = AW'(p0_x);
        start_left = CW'(n_x - p0_x);
      end
      sle_pkg::MODE_READ: begin
        if (pos_r == '0 || pos_x > n_x) begin
          chk_status = sle_pkg::STAT_BAD_POS;
        end else begin
          needs_stream = 1'b1;
        end
        start_addr = AW'(p0_x);
        start_left = CW'(1);
      end
      sle_pkg::MODE_LOCATE, sle_pkg::MODE_PRED, sle_pkg::MODE_SUCC: begin
        is_search    = 1'b1;
        needs_stream = 1'b1;
        start_left   = count_r;
      end
      default: begin
        needs_stream = 1'b0;
      end
    endcase
  end

  assign issue = cmd.stream && (left_r != '0) && !found_r && !pend_r;
  assign match = (rdata_r == val_r);

  // stage that consumes read data: shifting writes, value captures and search hits, plus the insert put write
  always_comb begin
    we        = 1'b0;
    waddr     = rd_addr_q_r;
    wdata     = rdata_r;
    cap_val   = 1'b0;
    cap_pos   = 1'b0;
    use_prev  = 1'b0;
    set_found = 1'b0;
    set_pend  = 1'b0;
    if (cmd.put) begin
      we    = 1'b1;
      waddr = AW'(p0_x);
      wdata = val_r;
    end else if (rd_vld_r) begin
      case (mode_r)
        sle_pkg::MODE_INSERT: begin
          we    = 1'b1;
          waddr = rd_addr_q_r + AW'(1);
        end
        sle_pkg::MODE_DELETE: begin
          if (rd_addr_q_r == AW'(p0_x)) begin
            cap_val = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = rd_addr_q_r - AW'(1);
          end
        end
        sle_pkg::MODE_READ: begin
          cap_val = 1'b1;
        end
        sle_pkg::MODE_LOCATE: begin
          if (!found_r && match) begin
            set_found = 1'b1;
            cap_pos   = 1'b1;
          end
        end
        sle_pkg::MODE_PRED: begin
          if (!found_r && match && rd_addr_q_r != '0) begin
            set_found = 1'b1;
            cap_val   = 1'b1;
            use_prev  = 1'b1;
          end
        end
        sle_pkg::MODE_SUCC: begin
          if (pend_r) begin
            set_found = 1'b1;
            cap_val   = 1'b1;
          end else if (!found_r && match && (CW'(rd_addr_q_r) + CW'(1)) < count_r) begin
            set_pend = 1'b1;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (mode_r)
      sle_pkg::MODE_CLEAR: begin
        count_nxt = '0;
      end
      sle_pkg::MODE_INSERT: begin
        if (status_r == sle_pkg::STAT_OK) count_nxt = count_r + CW'(1);
      end
      sle_pkg::MODE_DELETE: begin
        if (status_r == sle_pkg::STAT_OK) count_nxt = count_r - CW'(1);
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // list store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (issue) rdata_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.start) begin
        found_r <= 1'b0;
        pend_r  <= 1'b0;
      end else if (set_found) begin
        found_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (set_pend) begin
        pend_r <= 1'b1;
      end
      if (cmd.deliver) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_word.mode;
      pos_r  <= in_word.position;
      val_r  <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd.start) begin
      rd_addr_r <= start_addr;
      left_r    <= start_left;
      status_r  <= is_search ? sle_pkg::STAT_NOT_FOUND : chk_status;
      rval_r    <= '0;
      rpos_r    <= '0;
    end
    if (issue) begin
      rd_addr_q_r <= rd_addr_r;
      rd_addr_r   <= (mode_r == sle_pkg::MODE_INSERT) ? rd_addr_r - AW'(1)
                                                      : rd_addr_r + AW'(1);
      left_r      <= left_r - CW'(1);
    end
    if (rd_vld_r) prev_r <= rdata_r;
    if (cap_val) rval_r <= cap_ext[sle_pkg::VAL_W-1:0];
    if (cap_pos) rpos_r <= sle_pkg::POS_W'(CW'(rd_addr_q_r) + CW'(1));
    if (set_found) status_r <= sle_pkg::STAT_OK;
    if (cmd.deliver) begin
      out_word_r.status          <= status_r;
      out_word_r.result_value    <= rval_r;
      out_word_r.result_position <= rpos_r;
      out_word_r.list_length     <= sle_pkg::POS_W'(count_nxt);
    end
  end

  assign sts.go_stream   = needs_stream;
  assign sts.is_insert   = (mode_r == sle_pkg::MODE_INSERT);
  assign sts.stream_done = ((left_r == '0) || found_r || pend_r) && !rd_vld_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sv/sequential_list_engine_unit.sv @@
// path from accept to out_valid, n = entries in the list: clear, unused mode and rejected
// requests go from check straight to done; read walks one entry; locate/pred/succ at most n
// insert walks n - position + 1 entries (none when appending), then puts; delete n - position + 1
// throughput: one word at a time; the store walk of one entry a cycle sets the time per word
// reset: synchronous active-low rst_n empties the list; store contents stay undefined
// depends on sle_pkg, sle_ctrl, sle_dp and sequential_list_engine_unit_defines.svh
`include "sequential_list_engine_unit_defines.svh"

module sequential_list_engine_unit #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  sle_pkg::in_word_t  in_word,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output sle_pkg::out_word_t out_word
);

  // command and status between the sequencer and the datapath
  sle_pkg::cmd_t cmd;
  sle_pkg::sts_t sts;

  // sequencer: idle -> check -> stream over the store -> (put for insert) -> done; check goes to done if no walk
  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: list store with one write and one registered read port,
  // scan cursor that walks the list one entry a cycle, and the output register
  // that holds a finished word while the next request is taken
  sle_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  // once a word is taken the engine is busy with it for the next cycle
  `SLE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // a fresh result only comes out of the done state, never straight from idle
  `SLE_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall))

  // a full-store reject always reports a full list
  `SLE_ASSERT_IMP(a_full_len, clk, rst_n,
    out_valid && out_word.status == sle_pkg::STAT_FULL,
    out_word.list_length == sle_pkg::POS_W'(CAPACITY))

  // delivering a word always shows up as a valid result next cycle
  `SLE_ASSERT_NXT(a_deliver_valid, clk, rst_n, cmd.deliver, out_valid)

endmodule
